// File: src/dtdt_pkg.sv
package dtdt_pkg;

    localparam int FRAC_DIGITS = 6;
    localparam int INT_DIGITS  = 10;
    localparam int BUF_DEPTH   = 3 + INT_DIGITS + FRAC_DIGITS;
    localparam int IDX_W       = $clog2(BUF_DEPTH + 1);
    localparam int CHAR_W      = 7;
    localparam logic [31:0] INT_LIMIT = 32'h7FFF_FFFF;

    localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] CH_POINT = 7'h2E;
    localparam logic [CHAR_W-1:0] CH_MINUS = 7'h2D;

    // Classified item handed from front to back
    typedef struct packed {
        logic        err;
        logic        neg;
        logic [32:0] ip;
        logic [63:0] frac;
    } work_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_FRAC,
        BK_INT,
        BK_BUILD,
        BK_EMIT
    } bk_state_t;

endpackage

// File: src/double_to_decimal_text.sv
// Converts one binary64 bit pattern to "%.6f"-style text, one ASCII
// character per result.
// Input side: drive value_bits and raise push; the item transfers on a
// clock edge with push high and full low. A two-entry queue after the
// classifier absorbs up to two items while the back end is busy.
// Result side: while empty is low, text_char/last_char/range_error show
// the oldest character; it transfers on an edge with pop high.
// last_char marks the final character of one number. NaN, infinity and
// integer parts above 2^31-1 give a single result with range_error set.
// Steps: the item is taken from the queue, six fraction digits follow
// at one multiply by ten per cycle, then a rounding step on a seventh
// digit, the integer digits (reciprocal divide by ten) and one build
// step. Then one character shows per cycle while pop stays high, and
// the last one returns the sequencer to idle; an error result goes
// straight to output. The divide/multiply-by-ten unit sets the pace.
// A stalled receiver simply holds the current character; the front keeps
// accepting until the queue fills. Reset clears both queue and sequencer.
module double_to_decimal_text (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [63:0] value_bits,
    output logic        empty,
    input  logic        pop,
    output logic [6:0]  text_char,
    output logic        last_char,
    output logic        range_error
);
    import dtdt_pkg::*;

    work_t wq_data;
    logic  wq_valid;
    logic  wq_take;

    dtdt_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .value_bits (value_bits),
        .wq_valid   (wq_valid),
        .wq_take    (wq_take),
        .wq_data    (wq_data)
    );

    dtdt_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .wq_valid    (wq_valid),
        .wq_take     (wq_take),
        .wq_data     (wq_data),
        .empty       (empty),
        .pop         (pop),
        .text_char   (text_char),
        .last_char   (last_char),
        .range_error (range_error)
    );

endmodule

// File: src/dtdt_front.sv
module dtdt_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  logic [63:0]         value_bits,
    output logic                wq_valid,
    input  logic                wq_take,
    output dtdt_pkg::work_t     wq_data
);
    import dtdt_pkg::*;

    // Two-entry queue between classifier and back end
    work_t       q_reg [2];
    logic [1:0]  cnt_reg;
    logic        rd_reg;
    logic        wr_reg;
    work_t       w;

    logic        sgn;
    logic [10:0] expf;
    logic [52:0] mant;
    logic [11:0] sh;
    logic [63:0] ipw;
    logic [63:0] frac;
    logic        do_push;
    logic        do_pop;

    always_comb
    begin
        sgn  = value_bits[63];
        expf = value_bits[62:52];
        mant = {1'b0, value_bits[51:0]};
        ipw  = '0;
        frac = '0;
        if (expf == '0)
            sh = 12'd1074;
        else
        begin
            mant[52] = 1'b1;
            sh = 12'd1075 - {1'b0, expf};
        end
        if (expf == 11'h7FF || expf >= 11'd1075)
            sh = 12'd0;
        if (sh < 12'd64)
        begin
            ipw  = {11'd0, mant} >> sh[5:0];
            frac = (sh == 12'd0) ? 64'd0 : ({11'd0, mant} << (7'd64 - {1'b0, sh[5:0]}));
        end
        else if (sh < 12'd128)
            frac = {11'd0, mant} >> sh[5:0];
        w.err  = (expf == 11'h7FF) || (expf >= 11'd1075) || (ipw > {32'd0, INT_LIMIT});
        w.neg  = sgn && (value_bits[51:0] != '0 || expf != '0);
        w.ip   = {1'b0, ipw[31:0]};
        w.frac = frac;
    end

    assign full     = (cnt_reg == 2'd2);
    assign do_push  = push && !full;
    assign wq_valid = (cnt_reg != 2'd0);
    assign do_pop   = wq_take && wq_valid;
    assign wq_data  = q_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
            q_reg[wr_reg] <= w;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            rd_reg  <= 1'b0;
            wr_reg  <= 1'b0;
        end
        else
        begin
            if (do_push)
                wr_reg <= !wr_reg;
            if (do_pop)
                rd_reg <= !rd_reg;
            cnt_reg <= cnt_reg + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= 2'd2)
        else $error("queue count overflow");
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        full |=> cnt_reg != 2'd0)
        else $error("full queue drained too fast");
    a_ptr_sync: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd0 || cnt_reg == 2'd2) |-> rd_reg == wr_reg)
        else $error("queue pointers out of step");

endmodule

// File: src/dtdt_back.sv
module dtdt_back (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      wq_valid,
    output logic                      wq_take,
    input  dtdt_pkg::work_t           wq_data,
    output logic                      empty,
    input  logic                      pop,
    output logic [6:0]                text_char,
    output logic                      last_char,
    output logic                      range_error
);
    import dtdt_pkg::*;

    bk_state_t              st_reg, st_next;
    logic [CHAR_W-1:0]      buf_reg [BUF_DEPTH];
    logic [3:0]             fd_reg [FRAC_DIGITS];
    logic [3:0]             id_reg [INT_DIGITS+1];
    logic [63:0]            frac_reg;
    logic [32:0]            ip_reg;
    logic                   neg_reg;
    logic [IDX_W-1:0]       step_reg;
    logic [3:0]             nint_reg;
    logic [IDX_W-1:0]       emit_index_reg;
    logic [IDX_W-1:0]       char_count_reg;
    logic                   err_out_reg;

    logic [67:0]            f10;
    logic [3:0]             dig;
    logic [32:0]            q10;
    logic [3:0]             r10;
    logic [65:0]            qmul;
    logic                   carry;
    logic [3:0]             fd_inc [FRAC_DIGITS];
    logic [CHAR_W-1:0]      bld [BUF_DEPTH];
    logic [IDX_W-1:0]       pos;
    logic                   do_emit;

    // Times ten: carry-out is the next digit
    assign f10 = {4'd0, frac_reg} * 68'd10;
    assign dig = f10[67:64];

    // Divide by ten through reciprocal, one digit per cycle
    always_comb
    begin
        qmul = {33'd0, ip_reg} * 66'h0_CCCC_CCCD;
        q10  = {2'b0, qmul[65:35]};
        r10  = 4'(ip_reg - q10 * 33'd10);
        if (r10 >= 4'd10)
        begin
            q10 = q10 + 33'd1;
            r10 = r10 - 4'd10;
        end
    end

    // Round up the fraction digits
    always_comb
    begin
        carry = 1'b1;
        for (int i = FRAC_DIGITS - 1; i >= 0; i--)
        begin
            fd_inc[i] = fd_reg[i];
            if (carry)
            begin
                if (fd_reg[i] == 4'd9)
                    fd_inc[i] = 4'd0;
                else
                begin
                    fd_inc[i] = fd_reg[i] + 4'd1;
                    carry = 1'b0;
                end
            end
        end
    end

    always_comb
    begin
        pos = '0;
        for (int i = 0; i < BUF_DEPTH; i++)
            bld[i] = CH_ZERO;
        if (neg_reg)
        begin
            bld[0] = CH_MINUS;
            pos = IDX_W'(1);
        end
        for (int i = INT_DIGITS; i >= 0; i--)
            if (4'(i) < nint_reg)
            begin
                bld[pos] = CH_ZERO + {3'd0, id_reg[i]};
                pos = pos + IDX_W'(1);
            end
        bld[pos] = CH_POINT;
        pos = pos + IDX_W'(1);
        for (int i = 0; i < FRAC_DIGITS; i++)
        begin
            bld[pos] = CH_ZERO + {3'd0, fd_reg[i]};
            pos = pos + IDX_W'(1);
        end
    end

    assign do_emit = (st_reg == BK_EMIT) && pop;

    always_comb
    begin
        st_next = st_reg;
        wq_take = 1'b0;
        case (st_reg)
            BK_IDLE:
                if (wq_valid)
                begin
                    wq_take = 1'b1;
                    st_next = wq_data.err ? BK_EMIT : BK_FRAC;
                end
            BK_FRAC:
                if (step_reg == IDX_W'(FRAC_DIGITS))
                    st_next = BK_INT;
            BK_INT:
                if (ip_reg < 33'd10)
                    st_next = BK_BUILD;
            BK_BUILD:
                st_next = BK_EMIT;
            BK_EMIT:
                if (pop && (err_out_reg || emit_index_reg + IDX_W'(1) == char_count_reg))
                    st_next = BK_IDLE;
            default:
                st_next = BK_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        case (st_reg)
            BK_IDLE:
            begin
                frac_reg <= wq_data.frac;
                ip_reg   <= wq_data.ip;
                neg_reg  <= wq_data.neg;
            end
            BK_FRAC:
            begin
                frac_reg <= f10[63:0];
                if (step_reg < IDX_W'(FRAC_DIGITS))
                    fd_reg[step_reg[2:0]] <= dig;
                else if (dig >= 4'd5)
                begin
                    for (int i = 0; i < FRAC_DIGITS; i++)
                        fd_reg[i] <= fd_inc[i];
                    if (fd_reg[0] == 4'd9 && carry)
                        ip_reg <= ip_reg + 33'd1;
                end
            end
            BK_INT:
            begin
                id_reg[nint_reg] <= r10;
                ip_reg <= q10;
            end
            BK_BUILD:
                for (int i = 0; i < BUF_DEPTH; i++)
                    buf_reg[i] <= bld[i];
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg         <= BK_IDLE;
            step_reg       <= '0;
            nint_reg       <= '0;
            emit_index_reg <= '0;
            char_count_reg <= '0;
            err_out_reg    <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            case (st_reg)
                BK_IDLE:
                begin
                    step_reg       <= '0;
                    nint_reg       <= '0;
                    emit_index_reg <= '0;
                    err_out_reg    <= wq_valid && wq_data.err;
                    char_count_reg <= IDX_W'(1);
                end
                BK_FRAC:
                    step_reg <= step_reg + IDX_W'(1);
                BK_INT:
                    nint_reg <= nint_reg + 4'd1;
                BK_BUILD:
                    char_count_reg <= IDX_W'(neg_reg) + IDX_W'(nint_reg) + IDX_W'(1 + FRAC_DIGITS);
                BK_EMIT:
                    if (do_emit)
                        emit_index_reg <= emit_index_reg + IDX_W'(1);
                default:
                begin
                end
            endcase
        end
    end

    assign empty       = (st_reg != BK_EMIT);
    assign text_char   = err_out_reg ? '0 : buf_reg[emit_index_reg];
    assign last_char   = err_out_reg || (emit_index_reg + IDX_W'(1) == char_count_reg);
    assign range_error = err_out_reg;

    a_idx_in_text: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> emit_index_reg < char_count_reg)
        else $error("emit index beyond text");
    a_int_digits: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg == BK_INT |-> nint_reg <= 4'(INT_DIGITS))
        else $error("too many integer digits");
    a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
        wq_take |-> st_reg == BK_IDLE)
        else $error("queue read while busy");
    a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && err_out_reg) |-> last_char)
        else $error("error result not single");

endmodule
